[rtl/mpq_pkg.sv]
// Shared types and codes for the max priority queue.
// No dependencies; used by mpq_cell and max_priority_queue.
package mpq_pkg;

  localparam int unsigned PriW = 16;
  localparam int unsigned TagW = 8;
  localparam int unsigned CountOutW = 7;

  typedef logic signed [PriW-1:0] pri_t;
  typedef logic [TagW-1:0] tag_t;

  // request kinds on tuser
  localparam logic OpInsert = 1'b0;
  localparam logic OpRemove = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    StInserted = 2'd0,
    StRemoved  = 2'd1,
    StFull     = 2'd2,
    StEmpty    = 2'd3
  } status_e;

  // shift control broadcast along the cell row
  typedef struct packed {
    logic ins_en;
    logic rem_en;
  } cell_ctrl_t;

endpackage

[rtl/mpq_cell.sv]
// One slot of the sorted cell row: holds a priority and a tag.
// Depends on mpq_pkg.
module mpq_cell (
  input  logic                clk_i,
  input  mpq_pkg::cell_ctrl_t ctrl_i,
  input  logic                cell_valid_i,
  input  mpq_pkg::pri_t       new_pri_i,
  input  mpq_pkg::tag_t       new_tag_i,
  input  logic                prev_before_i,
  input  mpq_pkg::pri_t       prev_pri_i,
  input  mpq_pkg::tag_t       prev_tag_i,
  input  mpq_pkg::pri_t       next_pri_i,
  input  mpq_pkg::tag_t       next_tag_i,
  output logic                before_o,
  output mpq_pkg::pri_t       pri_o,
  output mpq_pkg::tag_t       tag_o
);

  mpq_pkg::pri_t pri_q, pri_d;
  mpq_pkg::tag_t tag_q, tag_d;

  // strict compare keeps equal priorities in arrival order
  assign before_o = !cell_valid_i || (new_pri_i > pri_q);

  always_comb begin
    pri_d = pri_q;
    tag_d = tag_q;
    if (ctrl_i.rem_en) begin
      pri_d = next_pri_i;
      tag_d = next_tag_i;
    end else if (ctrl_i.ins_en && before_o) begin
      if (prev_before_i) begin
        pri_d = prev_pri_i;
        tag_d = prev_tag_i;
      end else begin
        pri_d = new_pri_i;
        tag_d = new_tag_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pri_q <= pri_d;
    tag_q <= tag_d;
  end

  assign pri_o = pri_q;
  assign tag_o = tag_q;

endmodule

[rtl/max_priority_queue.sv]
// Top level of the max priority queue: stream ports, fill count, cell row.
// Depends on mpq_pkg and mpq_cell.

// A bounded queue of up to DEPTH entries kept sorted in a row of cells, the
// highest priority at the head and equal priorities in arrival order. Each
// request is an insert (tuser 0) or a remove (tuser 1) and gives exactly one
// result, registered in the cycle after it is taken. A new request can be
// taken every cycle while the result port is not stalled, as the whole row
// shifts by one cell on insert or remove. An insert into a full queue and a
// remove from an empty one leave the queue untouched and report their own
// status. No clearing pass after reset: only the fill count and out_valid_q reset.
module max_priority_queue #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // [15:0] priority_req, [23:16] tag
  input  logic [0:0]  s_axis_tuser_i,  // [0] op
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // [15:0] out_priority, [23:16] out_tag,
                                       // [30:24] count, [31] zero
  output logic [1:0]  m_axis_tuser_o   // [1:0] status
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0]       count_q, count_d;
  logic                out_valid_q;
  mpq_pkg::status_e    status_q, status_d;
  mpq_pkg::pri_t       opri_q, opri_d;
  mpq_pkg::tag_t       otag_q, otag_d;
  logic [6:0]          ocount_q, ocount_d;
  logic [CW+6:0]       count_ext;

  logic                accept;
  logic                is_remove;
  logic                full, empty;
  mpq_pkg::cell_ctrl_t ctrl;
  mpq_pkg::pri_t       new_pri;
  mpq_pkg::tag_t       new_tag;

  mpq_pkg::pri_t       pri_w    [DEPTH];
  mpq_pkg::tag_t       tag_w    [DEPTH];
  logic                before_w [DEPTH];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign is_remove = (s_axis_tuser_i[0] == mpq_pkg::OpRemove);
  assign new_pri   = s_axis_tdata_i[15:0];
  assign new_tag   = s_axis_tdata_i[23:16];
  assign full      = (count_q == CW'(DEPTH));
  assign empty     = (count_q == '0);

  assign ctrl.ins_en = accept && !is_remove && !full;
  assign ctrl.rem_en = accept && is_remove && !empty;

  always_comb begin
    count_d  = count_q;
    status_d = mpq_pkg::StInserted;
    opri_d   = '0;
    otag_d   = '0;
    if (!is_remove) begin
      if (full) begin
        status_d = mpq_pkg::StFull;
      end else begin
        count_d = count_q + 1'b1;
      end
    end else begin
      if (empty) begin
        status_d = mpq_pkg::StEmpty;
      end else begin
        status_d = mpq_pkg::StRemoved;
        opri_d   = pri_w[0];
        otag_d   = tag_w[0];
        count_d  = count_q - 1'b1;
      end
    end
  end

  // count is reported in 7 bits, wrapping for very deep queues
  assign count_ext = {7'b0, count_d};
  assign ocount_d  = count_ext[6:0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    mpq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .cell_valid_i (count_q > CW'(i)),
      .new_pri_i    (new_pri),
      .new_tag_i    (new_tag),
      .prev_before_i((i == 0) ? 1'b0 : before_w[(i == 0) ? 0 : i - 1]),
      .prev_pri_i   (pri_w[(i == 0) ? 0 : i - 1]),
      .prev_tag_i   (tag_w[(i == 0) ? 0 : i - 1]),
      .next_pri_i   (pri_w[(i == DEPTH - 1) ? i : i + 1]),
      .next_tag_i   (tag_w[(i == DEPTH - 1) ? i : i + 1]),
      .before_o     (before_w[i]),
      .pri_o        (pri_w[i]),
      .tag_o        (tag_w[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      opri_q   <= opri_d;
      otag_q   <= otag_d;
      ocount_q <= ocount_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, ocount_q, otag_q, opri_q};
  assign m_axis_tuser_o  = status_q;

endmodule
